### rtl/rgb2yuv_pkg.sv
// Shared types, plane codes and register indexes of the RGB to YUV 4:2:0 converter.
package rgb2yuv_pkg;

   localparam int unsigned CompWidth  = 8;
   localparam int unsigned CountWidth = 12;
   localparam int unsigned SizeWidth  = 13;
   localparam int unsigned SumWidth   = 18;

   localparam logic [SizeWidth-1:0] FrameWidthReset  = 13'd256;
   localparam logic [SizeWidth-1:0] FrameHeightReset = 13'd256;

   typedef logic [CompWidth-1:0] comp_type;

   typedef enum logic [1:0] {
      PLANE_Y = 2'd0,
      PLANE_U = 2'd1,
      PLANE_V = 2'd2
   } plane_type;

   typedef enum logic {
      REG_FRAME_WIDTH  = 1'b0,
      REG_FRAME_HEIGHT = 1'b1
   } reg_index_type;

   // Position of one pixel within the frame, captured when it is accepted.
   typedef struct packed {
      logic chroma;      // even column: a chroma sample follows the luma
      logic odd_row;     // chroma is V rather than U
      logic frame_last;  // last pixel of the frame
   } pix_flags_type;

   typedef struct packed {
      comp_type red;
      comp_type green;
      comp_type blue;
   } pixel_type;

endpackage

### rtl/rgb_to_yuv420_converter.sv
// Top level of the BT.601 RGB24 to YUV 4:2:0 sample stream converter.
//
// Pixels enter in raster order, one RGB24 pixel per req transaction; every
// pixel yields a Y sample, and a pixel on an even column yields a chroma
// sample right after it (U on even rows, V on odd rows). Column and row
// counters wrap at frame_width and frame_height (register 0 and 1 of the
// csr port, reset 256 each); a size of 0 acts as 1 and sizes above 4096
// act as 4096. Writes to the csr port take effect at once and do not clear
// the counters, so change the frame size only while the converter is idle.
// Data path: a pixel sits in the input register while the color matrix
// works, then lands in the result register once that is free, and its Y
// sample is offered on rsp from there. The single rsp channel sets the
// rate: it carries one sample per transaction, so an odd-column pixel
// takes one rsp transaction and an even-column pixel two. The input
// register takes the next pixel while results still wait on rsp_tready.
// rsp_tuser carries the plane (0 Y, 1 U, 2 V), rsp_tlast marks the last
// sample of the frame's last pixel, and rsp_tdata bit 8 marks the last
// sample of each pixel.
module rgb_to_yuv420_converter (
   input  logic                              clock,
   input  logic                              reset,
   // configuration writes
   input  logic                              csr_we,
   input  logic                              csr_addr,
   input  logic [rgb2yuv_pkg::SizeWidth-1:0] csr_wdata,
   // pixel input
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [23:0]                       req_tdata,  // red, green, blue
   // sample output
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [15:0]                       rsp_tdata,  // sample, last_of_pixel, zero fill
   output logic [1:0]                        rsp_tuser,  // plane
   output logic                              rsp_tlast   // frame_end
);
   import rgb2yuv_pkg::*;

   // Input register: pixel and its position flags.
   logic          in_valid_ff, in_valid_in;
   pixel_type     in_pixel_ff, in_pixel_in;
   pix_flags_type in_flags_ff, in_flags_in;

   // Result register: both samples of one pixel, sent one per transaction.
   logic       out_valid_ff, out_valid_in;
   logic       out_phase_ff, out_phase_in;  // 0: luma pending, 1: chroma pending
   logic       out_has_c_ff, out_has_c_in;
   logic       out_flast_ff, out_flast_in;
   comp_type   out_y_ff,     out_y_in;
   comp_type   out_c_ff,     out_c_in;
   plane_type  out_plane_ff, out_plane_in;

   pix_flags_type pos_flags;
   comp_type      mat_y;
   comp_type      mat_c;
   plane_type     mat_plane;

   logic req_take;
   logic rsp_take;
   logic out_last_now;
   logic out_free;
   logic out_load;
   logic last_of_pixel;
   comp_type  rsp_sample;
   plane_type rsp_plane;

   assign req_take     = req_tvalid && req_tready;
   assign rsp_take     = rsp_tvalid && rsp_tready;
   assign out_last_now = out_phase_ff || !out_has_c_ff;
   // The result register frees up in the cycle its final sample leaves.
   assign out_free     = !out_valid_ff || (rsp_tready && out_last_now);
   assign out_load     = in_valid_ff && out_free;
   assign req_tready   = !in_valid_ff || out_free;

   rgb2yuv_position u_position (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .advance   (req_take),
      .flags     (pos_flags)
   );

   rgb2yuv_matrix u_matrix (
      .pixel        (in_pixel_ff),
      .odd_row      (in_flags_ff.odd_row),
      .luma         (mat_y),
      .chroma       (mat_c),
      .chroma_plane (mat_plane)
   );

   // Input stage: capture a pixel, drop it once it moves on.
   always_comb begin
      in_valid_in = in_valid_ff;
      in_pixel_in = in_pixel_ff;
      in_flags_in = in_flags_ff;
      if (req_take) begin
         in_valid_in       = 1'b1;
         in_pixel_in.red   = req_tdata[7:0];
         in_pixel_in.green = req_tdata[15:8];
         in_pixel_in.blue  = req_tdata[23:16];
         in_flags_in       = pos_flags;
      end else if (out_load) begin
         in_valid_in = 1'b0;
      end
   end

   // Result stage: load both samples, then advance luma to chroma.
   always_comb begin
      out_valid_in = out_valid_ff;
      out_phase_in = out_phase_ff;
      out_has_c_in = out_has_c_ff;
      out_flast_in = out_flast_ff;
      out_y_in     = out_y_ff;
      out_c_in     = out_c_ff;
      out_plane_in = out_plane_ff;
      if (out_load) begin
         out_valid_in = 1'b1;
         out_phase_in = 1'b0;
         out_has_c_in = in_flags_ff.chroma;
         out_flast_in = in_flags_ff.frame_last;
         out_y_in     = mat_y;
         out_c_in     = mat_c;
         out_plane_in = mat_plane;
      end else if (rsp_take) begin
         if (out_last_now) begin
            out_valid_in = 1'b0;
         end else begin
            out_phase_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         out_phase_ff <= 1'b0;
         out_has_c_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         out_phase_ff <= out_phase_in;
         out_has_c_ff <= out_has_c_in;
      end
      in_pixel_ff  <= in_pixel_in;
      in_flags_ff  <= in_flags_in;
      out_flast_ff <= out_flast_in;
      out_y_ff     <= out_y_in;
      out_c_ff     <= out_c_in;
      out_plane_ff <= out_plane_in;
   end

   // Select the sample pending in the result register.
   assign rsp_sample    = out_phase_ff ? out_c_ff : out_y_ff;
   assign rsp_plane     = out_phase_ff ? out_plane_ff : PLANE_Y;
   assign last_of_pixel = out_last_now;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {7'b0, last_of_pixel, rsp_sample};
   assign rsp_tuser  = rsp_plane;
   assign rsp_tlast  = out_last_now && out_flast_ff;

`ifndef NO_ASSERTIONS
   // A luma sample that is not the pixel's last is followed by its chroma.
   assert property (@(posedge clock) disable iff (reset)
      rsp_take && !rsp_tdata[8] |=> rsp_tvalid && rsp_tuser != PLANE_Y)
      else $error("chroma sample missing after luma");

   // The chroma phase exists only for pixels that carry chroma.
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_phase_ff |-> out_has_c_ff)
      else $error("chroma phase without chroma sample");

   // A frame end only ever marks the last sample of a pixel.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tdata[8])
      else $error("frame end on a non-final sample");

   // An input pixel held while the result register is busy is not lost.
   assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !out_free |=> in_valid_ff && $stable(in_pixel_ff))
      else $error("held pixel lost");
`endif

endmodule

### rtl/rgb2yuv_position.sv
// Frame size registers and the column and row counters of the converter.
module rgb2yuv_position (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic                            csr_addr,
   input  logic [rgb2yuv_pkg::SizeWidth-1:0] csr_wdata,
   input  logic                            advance,
   output rgb2yuv_pkg::pix_flags_type      flags
);
   import rgb2yuv_pkg::*;

   logic [SizeWidth-1:0]  width_ff,  width_in;
   logic [SizeWidth-1:0]  height_ff, height_in;
   logic [CountWidth-1:0] col_ff,    col_in;
   logic [CountWidth-1:0] row_ff,    row_in;
   logic [SizeWidth-1:0]  col_plus;
   logic [SizeWidth-1:0]  row_plus;
   logic                  col_wrap;
   logic                  row_wrap;

   // A carry out of the 12-bit counter wraps it regardless of the size.
   assign col_plus = {1'b0, col_ff} + 13'd1;
   assign row_plus = {1'b0, row_ff} + 13'd1;
   assign col_wrap = col_plus[SizeWidth-1] || (col_plus >= width_ff);
   assign row_wrap = row_plus[SizeWidth-1] || (row_plus >= height_ff);

   assign flags.chroma     = ~col_ff[0];
   assign flags.odd_row    = row_ff[0];
   assign flags.frame_last = col_wrap && row_wrap;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_we) begin
         unique case (reg_index_type'(csr_addr))
            REG_FRAME_WIDTH:  width_in  = csr_wdata;
            REG_FRAME_HEIGHT: height_in = csr_wdata;
            default:          width_in  = width_ff;
         endcase
      end
   end

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (advance) begin
         if (col_wrap) begin
            col_in = '0;
            row_in = row_wrap ? '0 : row_plus[CountWidth-1:0];
         end else begin
            col_in = col_plus[CountWidth-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= FrameWidthReset;
         height_ff <= FrameHeightReset;
         col_ff    <= '0;
         row_ff    <= '0;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
      end
   end

endmodule

### rtl/rgb2yuv_matrix.sv
// BT.601 integer color matrix: luma and one chroma sample from a pixel.
module rgb2yuv_matrix (
   input  rgb2yuv_pkg::pixel_type  pixel,
   input  logic                    odd_row,
   output rgb2yuv_pkg::comp_type   luma,
   output rgb2yuv_pkg::comp_type   chroma,
   output rgb2yuv_pkg::plane_type  chroma_plane
);
   import rgb2yuv_pkg::*;

   logic signed [SumWidth-1:0] r_s, g_s, b_s;
   logic signed [SumWidth-1:0] y_sum, u_sum, v_sum, c_sum;
   logic signed [SumWidth-1:0] y_shift, c_shift;

   assign r_s = signed'({10'b0, pixel.red});
   assign g_s = signed'({10'b0, pixel.green});
   assign b_s = signed'({10'b0, pixel.blue});

   assign y_sum = 18'sd66 * r_s + 18'sd129 * g_s + 18'sd25 * b_s + 18'sd128;
   assign u_sum = 18'sd112 * b_s - 18'sd38 * r_s - 18'sd74 * g_s + 18'sd128;
   assign v_sum = 18'sd112 * r_s - 18'sd94 * g_s - 18'sd18 * b_s + 18'sd128;
   assign c_sum = odd_row ? v_sum : u_sum;

   // Arithmetic shift floors; the low byte plus offset wraps modulo 256.
   assign y_shift = y_sum >>> 8;
   assign c_shift = c_sum >>> 8;

   assign luma         = y_shift[CompWidth-1:0] + 8'd16;
   assign chroma       = c_shift[CompWidth-1:0] + 8'd128;
   assign chroma_plane = odd_row ? PLANE_V : PLANE_U;

endmodule
